### rtl/core/dequ_pkg.sv
// shared codes, widths and the response beat type for the double-ended queue
// no dependencies

package dequ_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int ACT_W  = 3;
    localparam int WORD_W = 32;
    localparam int OCC_W  = 9;
    localparam int STAT_W = 2;

    // request actions
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_FRONT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ_BACK  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SIZE       = 3'd6;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd7;

    // result status
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // registered result beat, minus the word that comes from the ring ram
    typedef struct packed {
        logic              done;
        logic              take_data;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } resp_t;

endpackage

### rtl/core/dequ_ram.sv
// ring store of the queue: single port synchronous ram, registered read
// depends on dequ_pkg

module dequ_ram
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/dequ_ctrl.sv
// front pointer and count bookkeeping, ram address generation, result status
// depends on dequ_pkg

module dequ_ctrl
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [ACT_W-1:0]  action,
    input  logic [WORD_W-1:0] push_word,
    output logic              mem_en,
    output logic              mem_we,
    output logic [AW-1:0]     mem_addr,
    output logic [WORD_W-1:0] mem_wdata,
    output resp_t             resp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    resp_t         resp_reg, resp_next;

    logic          is_empty, is_full, needs_word;
    logic [AW-1:0] front_inc, front_dec, tail_idx, back_idx;
    logic [SW-1:0] tail_sum, back_sum;
    logic          touch, write;
    logic [AW-1:0] addr;
    logic [STAT_W-1:0] st;
    logic          take;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));

    // ring wrap without a divider: values stay below twice the depth
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign tail_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_sum  = tail_sum - SW'(1);
    assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                : AW'(tail_sum);
    assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : AW'(back_sum);

    assign needs_word = action inside {ACT_POP_FRONT, ACT_POP_BACK,
                                       ACT_READ_FRONT, ACT_READ_BACK};

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        st         = ST_OK;
        take       = 1'b0;
        touch      = 1'b0;
        write      = 1'b0;
        addr       = front_reg;
        if (needs_word && is_empty)
        begin
            st = ST_EMPTY;
        end
        else
        begin
            case (action)
                ACT_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                        touch      = 1'b1;
                        write      = 1'b1;
                        addr       = front_dec;
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        touch      = 1'b1;
                        write      = 1'b1;
                        addr       = tail_idx;
                    end
                end
                ACT_POP_FRONT:
                begin
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                    touch      = 1'b1;
                    take       = 1'b1;
                end
                ACT_POP_BACK:
                begin
                    count_next = count_reg - CW'(1);
                    touch      = 1'b1;
                    take       = 1'b1;
                    addr       = back_idx;
                end
                ACT_READ_FRONT:
                begin
                    touch = 1'b1;
                    take  = 1'b1;
                end
                ACT_READ_BACK:
                begin
                    touch = 1'b1;
                    take  = 1'b1;
                    addr  = back_idx;
                end
                ACT_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    // size: nothing changes
                end
            endcase
        end
    end

    always_comb
    begin
        resp_next.done      = accept;
        resp_next.take_data = accept && take;
        resp_next.status    = st;
        resp_next.occupancy = OCC_W'(count_next);
    end

    assign mem_en    = accept && touch;
    assign mem_we    = write;
    assign mem_addr  = addr;
    assign mem_wdata = push_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            resp_reg  <= '0;
        end
        else
        begin
            resp_reg <= resp_next;
            if (accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    assign resp = resp_reg;

endmodule

### rtl/core/double_ended_queue_unit.sv
// top level of the double-ended queue: request port, control and ring ram
// depends on dequ_pkg, dequ_ctrl, dequ_ram

// Bounded double-ended queue of signed 32-bit words held in a ring ram of
// DEPTH entries. A request beat (action, push_word) is taken on a rising
// edge where start is high and busy is low. Exactly one result beat follows:
// done is high for one cycle, the cycle right after the request, carrying
// data_word, occupancy and status. The receiver cannot stall, so the block
// never holds a result back. A new request may be given every cycle; a read
// issued by one request lands in the ram output register on the edge that
// takes the request, and is shown on the next cycle. A push into a full queue
// drops the word and reports full; a pop or read of an empty queue reports
// empty with a zero word. busy is only high during reset and the first cycle
// after it. There is no clearing pass: clear only resets the pointers.

module double_ended_queue_unit
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [WORD_W-1:0] push_word,
    output logic                     done,
    output logic signed [WORD_W-1:0] data_word,
    output logic [OCC_W-1:0]         occupancy,
    output logic [STAT_W-1:0]        status
);

    localparam int AW = $clog2(DEPTH);

    logic              ready_reg;
    logic              accept;
    logic              mem_en;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;
    resp_t             resp;

    // ready is registered and comes up in the cycle after reset is released
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    assign busy   = !ready_reg;
    assign accept = start && ready_reg;

    // pointer bookkeeping and result status
    dequ_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .push_word (push_word),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .resp      (resp)
    );

    // ring store, at most one access per request
    dequ_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result beat: word only for a successful pop or read
    assign done      = resp.done;
    assign status    = resp.status;
    assign occupancy = resp.occupancy;
    assign data_word = resp.take_data ? $signed(mem_rdata) : '0;

`ifndef SYNTH
    // every accepted request gives exactly one result on the next cycle
    a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy))
        else $error("result beat does not match accepted request");

    // an error result never carries a word
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (data_word == '0))
        else $error("error result carries a data word");

    // empty error reports an empty queue
    a_empty_occ : assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty error with nonzero occupancy");

    // clear always leaves an empty queue
    a_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_CLEAR) |=>
        (done && occupancy == '0 && status == ST_OK))
        else $error("clear did not empty the queue");
`endif

endmodule

### verif/dequ_reply_checker.sv
`timescale 1ns / 100ps
// reply checker for the double-ended queue: shadows the ring on every request beat
// and compares each result beat with the oldest owed reply; depends on dequ_pkg

module dequ_reply_checker
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [WORD_W-1:0] push_word,
    input  logic                     done,
    input  logic signed [WORD_W-1:0] data_word,
    input  logic [OCC_W-1:0]         occupancy,
    input  logic [STAT_W-1:0]        status,
    output int                       fail_count,
    output int                       owed_count
);

    localparam int OWED_DEPTH = 8;

    typedef struct {
        logic signed [WORD_W-1:0] word;
        logic [OCC_W-1:0]         occ;
        logic [STAT_W-1:0]        stat;
    } reply_t;

    logic signed [WORD_W-1:0] shadow_slots [DEPTH];
    int                       shadow_front;
    int                       shadow_count;
    reply_t                   owed_replies [OWED_DEPTH];
    int                       owed_head;
    int                       owed_tail;

    // one request applied to the shadow ring
    task automatic shadow_request(input logic [ACT_W-1:0] act,
                                  input logic signed [WORD_W-1:0] word,
                                  output reply_t r);
        int back;
        back   = (shadow_front + shadow_count + DEPTH - 1) % DEPTH;
        r.word = '0;
        r.stat = ST_OK;
        case (act)
            ACT_PUSH_FRONT:
                if (shadow_count >= DEPTH)
                    r.stat = ST_FULL;
                else
                begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_front] = word;
                    shadow_count++;
                end
            ACT_PUSH_BACK:
                if (shadow_count >= DEPTH)
                    r.stat = ST_FULL;
                else
                begin
                    shadow_slots[(shadow_front + shadow_count) % DEPTH] = word;
                    shadow_count++;
                end
            ACT_POP_FRONT:
                if (shadow_count == 0)
                    r.stat = ST_EMPTY;
                else
                begin
                    r.word = shadow_slots[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            ACT_POP_BACK:
                if (shadow_count == 0)
                    r.stat = ST_EMPTY;
                else
                begin
                    r.word = shadow_slots[back];
                    shadow_count--;
                end
            ACT_READ_FRONT:
                if (shadow_count == 0)
                    r.stat = ST_EMPTY;
                else
                    r.word = shadow_slots[shadow_front];
            ACT_READ_BACK:
                if (shadow_count == 0)
                    r.stat = ST_EMPTY;
                else
                    r.word = shadow_slots[back];
            ACT_CLEAR:
            begin
                shadow_front = 0;
                shadow_count = 0;
            end
            default:
                ;
        endcase
        r.occ = OCC_W'(shadow_count);
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        reply_t fresh;
        if (!rst_n)
        begin
            fail_count   = 0;
            owed_count   = 0;
            owed_head    = 0;
            owed_tail    = 0;
            shadow_front = 0;
            shadow_count = 0;
        end
        else
        begin
            // result beat belongs to an earlier request, so check it first
            if (done)
            begin
                if (owed_count == 0)
                begin
                    $display("%0t result beat with no reply owed: word %0d occ %0d stat %0d",
                             $time, data_word, occupancy, status);
                    fail_count++;
                end
                else
                begin
                    want      = owed_replies[owed_head];
                    owed_head = (owed_head + 1) % OWED_DEPTH;
                    owed_count--;
                    if (data_word !== want.word)
                    begin
                        $display("%0t data_word expected %0d actual %0d",
                                 $time, want.word, data_word);
                        fail_count++;
                    end
                    if (occupancy !== want.occ)
                    begin
                        $display("%0t occupancy expected %0d actual %0d",
                                 $time, want.occ, occupancy);
                        fail_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t status expected %0d actual %0d",
                                 $time, want.stat, status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                shadow_request(action, push_word, fresh);
                if (owed_count >= OWED_DEPTH)
                begin
                    $display("%0t too many owed replies: expected at most %0d actual %0d",
                             $time, OWED_DEPTH, owed_count + 1);
                    fail_count++;
                end
                else
                begin
                    owed_replies[owed_tail] = fresh;
                    owed_tail = (owed_tail + 1) % OWED_DEPTH;
                    owed_count++;
                end
            end
        end
    end

endmodule

### verif/tb_double_ended_queue_unit.sv
`timescale 1ns / 100ps
// stimulus and verdict for the double-ended queue unit
// depends on dequ_pkg, double_ended_queue_unit and dequ_reply_checker

module tb_double_ended_queue_unit
    import dequ_pkg::*;
();

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 252;
    localparam int RUN_LEN         = 62;

    // drift of the random mix so occupancy wanders between empty and full
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic [ACT_W-1:0]         action    = ACT_SIZE;
    logic signed [WORD_W-1:0] push_word = '0;
    logic                     busy;
    logic                     done;
    logic signed [WORD_W-1:0] data_word;
    logic [OCC_W-1:0]         occupancy;
    logic [STAT_W-1:0]        status;

    int   fail_count;
    int   owed_count;
    int   idle_pct     = 8;
    int   quiet_cycles = 0;
    mix_t mix          = MIX_EVEN;

    always #2 clk = ~clk;

    double_ended_queue_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .push_word (push_word),
        .done      (done),
        .data_word (data_word),
        .occupancy (occupancy),
        .status    (status)
    );

    dequ_reply_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .push_word  (push_word),
        .done       (done),
        .data_word  (data_word),
        .occupancy  (occupancy),
        .status     (status),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    // watchdog: any accepted request or result beat restarts the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // each cycle the sender idles with chance idle_pct, then offers one
    // request beat and holds it until taken
    // start stays high into the next beat unless an idle cycle is drawn
    task automatic send_beat(input logic [ACT_W-1:0] act,
                             input logic signed [WORD_W-1:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        push_word <= word;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every owed reply has come back
    // owed count is looked at on the falling edge, clear of the checker update
    task automatic drain_replies;
        start <= 1'b0;
        @(negedge clk);
        while (owed_count != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // mostly full-range words, with the extremes mixed in
    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] rand_action(input mix_t m);
        int roll;
        int push_pct;
        roll     = $urandom_range(99);
        push_pct = (m == MIX_GROW) ? 80 : (m == MIX_SHRINK) ? 20 : 50;
        // clear only in the even mix so growth runs can reach full
        if (roll < 2 && m == MIX_EVEN)
            return ACT_CLEAR;
        if (roll < 8)
            return ACT_SIZE;
        if (roll < 16)
            return $urandom_range(1) ? ACT_READ_BACK : ACT_READ_FRONT;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: every pop and read reports empty, size and clear are ok
        send_beat(ACT_POP_FRONT, rand_word());
        send_beat(ACT_POP_BACK, rand_word());
        send_beat(ACT_READ_FRONT, rand_word());
        send_beat(ACT_READ_BACK, rand_word());
        send_beat(ACT_SIZE, rand_word());
        send_beat(ACT_CLEAR, rand_word());

        // push front from pointer zero wraps to the top of the ring
        send_beat(ACT_PUSH_FRONT, 32'sh8000_0000);
        send_beat(ACT_PUSH_BACK, 32'sh7fff_ffff);
        send_beat(ACT_PUSH_FRONT, -32'sd1);
        send_beat(ACT_PUSH_BACK, 32'sh0000_0000);
        send_beat(ACT_READ_FRONT, 32'sh1234_5678);
        send_beat(ACT_READ_BACK, 32'sh1234_5678);
        send_beat(ACT_SIZE, 32'sh0);
        send_beat(ACT_POP_BACK, 32'sh0);
        send_beat(ACT_POP_FRONT, 32'sh0);
        send_beat(ACT_PUSH_FRONT, 32'sh5555_5555);
        send_beat(ACT_PUSH_BACK, 32'shaaaa_aaaa);
        send_beat(ACT_POP_FRONT, 32'sh0);
        send_beat(ACT_POP_BACK, 32'sh0);
        send_beat(ACT_POP_BACK, 32'sh0);
        send_beat(ACT_POP_FRONT, 32'sh0);
        send_beat(ACT_POP_FRONT, 32'sh0);

        // clear with words held and the front pointer off zero
        send_beat(ACT_PUSH_FRONT, rand_word());
        send_beat(ACT_CLEAR, rand_word());
        send_beat(ACT_READ_BACK, rand_word());

        // fill to the brim, push into full from both ends, then drain
        for (int i = 0; i < DEPTH_DEFAULT; i++)
            send_beat($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, rand_word());
        send_beat(ACT_PUSH_FRONT, rand_word());
        send_beat(ACT_PUSH_BACK, rand_word());
        send_beat(ACT_SIZE, rand_word());
        send_beat(ACT_READ_FRONT, rand_word());
        send_beat(ACT_READ_BACK, rand_word());
        for (int i = 0; i < DEPTH_DEFAULT; i++)
            send_beat($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, rand_word());
        send_beat(ACT_POP_BACK, rand_word());

        // random phases: light sender gaps, heavy gaps, then back to back
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 8 : (phase == 1) ? 79 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % RUN_LEN == 0)
                    mix = mix_t'($urandom_range(2));
                send_beat(rand_action(mix), rand_word());
            end
            // sender pauses until the queue of owed replies runs dry
            drain_replies();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
